FILE: src/ppm_ptg_pkg.sv
// ----------------------------------------------------------------------------
// ppm_ptg_pkg
// Types, register map and constants of the PPM pulse train generator.
// ----------------------------------------------------------------------------
package ppm_ptg_pkg;

  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_TIME_BITS    = 20;

  localparam int CNT_W   = 5;
  localparam int SW_W    = 12;
  localparam int FL_W    = 20;
  localparam int FS_W    = 16;
  localparam int VAL_W   = 16;
  localparam int CHIDX_W = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SYNC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 3'd6;

  localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 5'd8;
  localparam logic [SW_W-1:0]  RST_SYNC_WIDTH    = 12'd300;
  localparam logic [FL_W-1:0]  RST_FRAME_LENGTH  = 20'd22500;
  localparam logic [FS_W-1:0]  RST_FRAME_SYNC    = 16'd3000;
  localparam logic             RST_INVERT        = 1'b0;
  localparam logic [VAL_W-1:0] RST_MIN_VALUE     = 16'd1000;
  localparam logic [VAL_W-1:0] RST_MAX_VALUE     = 16'd2000;

  localparam logic [VAL_W-1:0] CENTER_VALUE = 16'd1500;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_FRAME_IDLE = 3'd1,
    PH_SYNC       = 3'd2,
    PH_CHAN_IDLE  = 3'd3,
    PH_FINAL      = 3'd4,
    PH_FILL       = 3'd5
  } phase_t;

  typedef struct packed {
    logic               mode;
    logic [CHIDX_W-1:0] channel_index;
    logic [VAL_W-1:0]   channel_value;
  } in_req_t;

  typedef struct packed {
    logic ppm_level;
    logic frame_start;
    logic write_accepted;
  } out_rsp_t;

endpackage

FILE: src/ppm_pulse_train_generator.sv
// ----------------------------------------------------------------------------
// ppm_pulse_train_generator
// PPM encoder: each tick request advances the frame timebase and returns the
// line level; channel writes land in a two-slot value RAM and go live at the
// next frame start.
// ----------------------------------------------------------------------------
// Channel  Ports                           Request
// in       in_valid, in_stall, in_data     one tick or one channel write
// out      out_valid, out_stall, out_data  one response per request
// cfg      cfg_we, cfg_index, cfg_data     register write, no wait state
//
// One request per clock unless stalled; its response fills the output
// register next cycle. Channel values live in a single-port RAM read once per
// tick (the value of the channel in progress) and written once per accepted
// write. Reset is synchronous; per-slot valid bits stand in for the reset
// contents, so no clearing pass. in_stall is high only while a response waits.
// ----------------------------------------------------------------------------
module ppm_pulse_train_generator #(
  parameter int MAX_CHANNELS = ppm_ptg_pkg::DEF_MAX_CHANNELS,
  parameter int TIME_BITS    = ppm_ptg_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ppm_ptg_pkg::in_req_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ppm_ptg_pkg::out_rsp_t               out_data,
  input  logic                                cfg_we,
  input  logic [ppm_ptg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppm_ptg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppm_ptg_pkg::*;

  localparam int IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int FW        = (TIME_BITS > FL_W) ? TIME_BITS : FL_W;
  localparam logic [FW-1:0] TMAX_W = FW'({TIME_BITS{1'b1}});

  // configuration
  logic [CNT_W-1:0] cfg_cnt_r;
  logic [SW_W-1:0]  cfg_sw_r;
  logic [FL_W-1:0]  cfg_fl_r;
  logic [FS_W-1:0]  cfg_fs_r;
  logic             cfg_inv_r;
  logic [VAL_W-1:0] cfg_min_r;
  logic [VAL_W-1:0] cfg_max_r;

  // handshake and response
  logic     out_valid_r;
  out_rsp_t out_data_r;
  out_rsp_t out_nxt;
  logic     in_acc;
  logic     tick_acc;
  logic     wr_acc;
  logic     wr_ok;

  // frame state
  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] seg_r, seg_cur, seg_res, seg_nxt;
  logic [TIME_BITS-1:0] ft_r, ft_res, ft_nxt;
  logic [CNT_W-1:0]     ch_r, ch_nxt;
  logic                 defer_r, defer_nxt;
  logic                 frame_go;

  // value store
  logic [VAL_W-1:0]              mem_r [MEM_DEPTH];
  logic [VAL_W-1:0]              rd_data_r;
  logic                          rd_pend_r;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [VAL_W-1:0]              val_r, val_cur;
  logic [ADDR_W-1:0]             mem_addr;
  logic                          mem_we;
  logic [MAX_CHANNELS-1:0]       sel_r, dirty_r, sel_new;
  logic [1:0][MAX_CHANNELS-1:0]  vld_r, nz_r;
  logic [MAX_CHANNELS-1:0]       nz_old, nz_new, lt_cnt, ge_a, cand_a, cand_b;
  logic [IDX_W-1:0]              wr_idx, rd_idx;
  logic                          wr_slot, rd_slot, rd_ch_ok;

  // derived values
  logic [CNT_W-1:0]     cnt_eff;
  logic [CNT_W-1:0]     ea_start;
  logic                 found_a, found_b;
  logic [CNT_W-1:0]     c_a, c_b;
  logic                 sw_zero;
  logic                 v_gt;
  logic [FW-1:0]        fl_w, ft_w, fill_diff;
  logic [TIME_BITS-1:0] fill_a, fill_b;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cnt_r <= RST_CHANNEL_COUNT;
      cfg_sw_r  <= RST_SYNC_WIDTH;
      cfg_fl_r  <= RST_FRAME_LENGTH;
      cfg_fs_r  <= RST_FRAME_SYNC;
      cfg_inv_r <= RST_INVERT;
      cfg_min_r <= RST_MIN_VALUE;
      cfg_max_r <= RST_MAX_VALUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: cfg_cnt_r <= cfg_data[CNT_W-1:0];
        CFG_SYNC_WIDTH:    cfg_sw_r  <= cfg_data[SW_W-1:0];
        CFG_FRAME_LENGTH:  cfg_fl_r  <= cfg_data[FL_W-1:0];
        CFG_FRAME_SYNC:    cfg_fs_r  <= cfg_data[FS_W-1:0];
        CFG_INVERT:        cfg_inv_r <= cfg_data[0];
        CFG_MIN_VALUE:     cfg_min_r <= cfg_data[VAL_W-1:0];
        CFG_MAX_VALUE:     cfg_max_r <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign tick_acc = in_acc & (in_data.mode == MODE_TICK);
  assign wr_acc   = in_acc & (in_data.mode == MODE_WRITE);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_eff = ({1'b0, cfg_cnt_r} > (CNT_W + 1)'(MAX_CHANNELS)) ?
                   CNT_W'(MAX_CHANNELS) : cfg_cnt_r;
  assign sw_zero = (cfg_sw_r == '0);

  assign wr_ok = ({1'b0, in_data.channel_index} < cnt_eff) &&
                 ({2'b0, in_data.channel_index} < (CHIDX_W + 2)'(MAX_CHANNELS)) &&
                 (in_data.channel_value >= cfg_min_r) &&
                 (in_data.channel_value <= cfg_max_r);

  // --------------------------------------------------------------------------
  // current channel value and segment count
  // --------------------------------------------------------------------------
  assign val_cur = rd_pend_r ? (rd_vld_r ? rd_data_r : CENTER_VALUE) : val_r;
  assign seg_cur = defer_r ? (TIME_BITS'(val_cur) - TIME_BITS'(1)) : seg_r;
  assign v_gt    = val_cur > VAL_W'(cfg_sw_r);

  assign fl_w      = FW'(cfg_fl_r);
  assign ft_w      = FW'(ft_r);
  assign fill_diff = fl_w - ft_w;
  assign fill_a    = (fl_w > ft_w) ?
                     ((fill_diff > TMAX_W) ? TIME_BITS'(TMAX_W) : TIME_BITS'(fill_diff)) :
                     '0;
  assign fill_b    = (fl_w > TMAX_W) ? TIME_BITS'(TMAX_W) : TIME_BITS'(fl_w);

  assign ea_start = (phase_r == PH_FRAME_IDLE) ? '0 : ch_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      sel_new[i] = sel_r[i] ^ dirty_r[i];
      nz_old[i]  = ~vld_r[sel_r[i]][i] | nz_r[sel_r[i]][i];
      nz_new[i]  = ~vld_r[sel_new[i]][i] | nz_r[sel_new[i]][i];
      lt_cnt[i]  = CNT_W'(i) < cnt_eff;
      ge_a[i]    = CNT_W'(i) >= ea_start;
    end
  end

  assign cand_a  = nz_old & lt_cnt & ge_a;
  assign cand_b  = nz_new & lt_cnt;
  assign found_a = |cand_a;
  assign found_b = |cand_b;

  always_comb begin
    c_a = '0;
    c_b = '0;
    for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
      if (cand_a[i]) c_a = CNT_W'(i);
      if (cand_b[i]) c_b = CNT_W'(i);
    end
  end

  // --------------------------------------------------------------------------
  // next state: resolve zero-length segments within one tick
  // --------------------------------------------------------------------------
  always_comb begin
    logic go_e;
    logic go_fl;
    logic go_s;
    go_e      = 1'b0;
    go_fl     = 1'b0;
    go_s      = 1'b0;
    phase_nxt = phase_r;
    seg_res   = seg_cur;
    ch_nxt    = ch_r;
    ft_res    = ft_r;
    frame_go  = 1'b0;
    defer_nxt = 1'b0;

    if (phase_r == PH_START) begin
      go_s = 1'b1;
    end else if (seg_cur == '0) begin
      unique case (phase_r)
        PH_FRAME_IDLE: go_e = 1'b1;
        PH_SYNC: begin
          if (v_gt) begin
            phase_nxt = PH_CHAN_IDLE;
            seg_res   = TIME_BITS'(val_cur - VAL_W'(cfg_sw_r));
          end else begin
            go_e = 1'b1;
          end
        end
        PH_CHAN_IDLE: go_e = 1'b1;
        PH_FINAL:     go_fl = 1'b1;
        default:      go_s = 1'b1;
      endcase
    end

    if (go_e) begin
      if (sw_zero) begin
        if (found_a) begin
          phase_nxt = PH_CHAN_IDLE;
          ch_nxt    = c_a;
          defer_nxt = 1'b1;
        end else begin
          phase_nxt = PH_FINAL;
          go_fl     = 1'b1;
        end
      end else begin
        ch_nxt    = ea_start;
        phase_nxt = (ea_start < cnt_eff) ? PH_SYNC : PH_FINAL;
        seg_res   = TIME_BITS'(cfg_sw_r);
      end
    end

    if (go_fl) begin
      phase_nxt = PH_FILL;
      seg_res   = fill_a;
      if (fill_a == '0) go_s = 1'b1;
    end

    if (go_s) begin
      frame_go  = 1'b1;
      ft_res    = '0;
      ch_nxt    = '0;
      defer_nxt = 1'b0;
      phase_nxt = PH_FRAME_IDLE;
      seg_res   = TIME_BITS'(cfg_fs_r);
      if (cfg_fs_r == '0) begin
        if (sw_zero) begin
          if (found_b) begin
            phase_nxt = PH_CHAN_IDLE;
            ch_nxt    = c_b;
            defer_nxt = 1'b1;
          end else begin
            phase_nxt = PH_FILL;
            seg_res   = fill_b;
          end
        end else begin
          phase_nxt = (cnt_eff != '0) ? PH_SYNC : PH_FINAL;
          seg_res   = TIME_BITS'(cfg_sw_r);
        end
      end
    end
  end

  assign seg_nxt = (seg_res != '0) ? seg_res - TIME_BITS'(1) : '0;
  assign ft_nxt  = (ft_res != '1) ? ft_res + TIME_BITS'(1) : ft_res;

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  always_comb begin
    out_nxt = '0;
    if (in_data.mode == MODE_WRITE) begin
      out_nxt.ppm_level      = ((phase_r == PH_SYNC) || (phase_r == PH_FINAL)) ?
                               ~cfg_inv_r : cfg_inv_r;
      out_nxt.write_accepted = wr_ok;
    end else begin
      out_nxt.ppm_level   = ((phase_nxt == PH_SYNC) || (phase_nxt == PH_FINAL)) ?
                            ~cfg_inv_r : cfg_inv_r;
      out_nxt.frame_start = frame_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // frame state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      seg_r     <= TIME_BITS'(RST_FRAME_SYNC);
      ft_r      <= '0;
      ch_r      <= '0;
      defer_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= tick_acc;
      if (tick_acc) begin
        phase_r <= phase_nxt;
        seg_r   <= seg_nxt;
        ft_r    <= ft_nxt;
        ch_r    <= ch_nxt;
        defer_r <= defer_nxt;
      end else begin
        seg_r   <= seg_cur;
        defer_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_cur;
    rd_vld_r <= rd_vld_nxt;
  end

  // --------------------------------------------------------------------------
  // value store: two slots per channel, active slot chosen by sel_r
  // --------------------------------------------------------------------------
  assign wr_idx   = IDX_W'(in_data.channel_index);
  assign wr_slot  = ~sel_r[wr_idx];
  assign rd_ch_ok = {1'b0, ch_nxt} < (CNT_W + 1)'(MAX_CHANNELS);
  assign rd_idx   = rd_ch_ok ? IDX_W'(ch_nxt) : '0;
  assign rd_slot  = frame_go ? sel_new[rd_idx] : sel_r[rd_idx];
  assign rd_vld_nxt = rd_ch_ok & vld_r[rd_slot][rd_idx];

  assign mem_we   = wr_acc & wr_ok;
  assign mem_addr = wr_acc ? {wr_slot, wr_idx} : {rd_slot, rd_idx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= in_data.channel_value;
    end
    rd_data_r <= mem_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      dirty_r <= '0;
      vld_r   <= '0;
    end else if (tick_acc && frame_go) begin
      sel_r   <= sel_new;
      dirty_r <= '0;
    end else if (mem_we) begin
      dirty_r[wr_idx]        <= 1'b1;
      vld_r[wr_slot][wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nz_r[wr_slot][wr_idx] <= (in_data.channel_value != '0);
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_defer_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    defer_r |-> rd_pend_r)
    else $error("deferred segment load without read data");

  a_frame_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && frame_go) |=> (dirty_r == '0))
    else $error("pending channel values not promoted at frame start");

  a_rsp_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.frame_start && out_data_r.write_accepted))
    else $error("response flags both a frame start and a write");

endmodule
